// ----- hw/rtl/rsd_pkg.sv -----
// Shared types and constants for the RGBE scanline decoder.
// Depends on nothing; used by every module in hw/rtl but rsd_checker.
`default_nettype none
package rsd_pkg;
  localparam int MaxWidth = 4096;
  localparam int ColW = 13;
  localparam int IdxW = 12;

  // Request opcodes
  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RLE    = 2'd1,
    PH_FLAT   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_FILL  = 2'd1,
    BK_READ  = 2'd2,
    BK_READ2 = 2'd3
  } back_state_t;

  // Request from front to back: a span of buffer writes or a pixel read.
  typedef struct packed {
    logic            is_read;
    logic [IdxW-1:0] start;
    logic [ColW-1:0] count;
    logic [3:0]      lane_mask;
    logic [31:0]     pixel;
    logic            status;
    logic            line_done;
  } job_t;

  // Convert one mantissa/exponent pair into float32 bits.
  function automatic logic [31:0] chan_bits(input logic [7:0] m, input logic [7:0] e);
    logic [2:0] p;
    logic [8:0] s;
    logic [31:0] r;
    p = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (m[i]) p = 3'(i);
    end
    s = 9'(p) + 9'(e);
    r = 32'd0;
    if (e != 8'd0 && m != 8'd0) begin
      if (s >= 9'd10) begin
        r = {1'b0, 8'(s - 9'd9), 23'((32'(m) << (5'd23 - 5'(p))) & 32'h7FFFFF)};
      end else begin
        r = 32'(m) << (6'(e) + 6'd13);
      end
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/rgbe_scanline_decoder.sv -----
// Top level of the RGBE scanline decoder.
// Depends on rsd_pkg, rsd_front, rsd_queue, rsd_back.
`default_nettype none
// The front part parses each stream byte combinationally into a job; the back
// part then writes the line buffer one pixel entry per cycle. A pixel read goes
// through the registered buffer port. Results come out in request order
// through a one-entry output register.
module rgbe_scanline_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [12:0] cfg_line_width,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_opcode,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [11:0] in_pixel_index,
  output logic             empty,
  input  wire logic        pop,
  output logic             out_status,
  output logic             out_line_done,
  output logic [31:0]      out_red_bits,
  output logic [31:0]      out_green_bits,
  output logic [31:0]      out_blue_bits
);
  logic fj_valid, q_full, q_valid, q_pop;
  rsd_pkg::job_t fj, qj;

  rsd_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata(cfg_line_width),
    .in_push(push), .in_full(full), .in_opcode, .in_data_byte, .in_pixel_index,
    .job_valid(fj_valid), .job(fj), .job_full(q_full)
  );

  rsd_queue u_queue (
    .clk, .rst_n, .wr_en(fj_valid), .wr_job(fj), .full(q_full),
    .rd_valid(q_valid), .rd_job(qj), .rd_en(q_pop)
  );

  rsd_back u_back (
    .clk, .rst_n, .job_valid(q_valid), .job(qj), .job_pop(q_pop),
    .out_empty(empty), .out_pop(pop), .out_status, .out_line_done,
    .out_red_bits, .out_green_bits, .out_blue_bits
  );
endmodule
`default_nettype wire

// ----- hw/rtl/rsd_front.sv -----
// Front part: parses stream bytes and read requests into jobs.
// Depends on rsd_pkg.
`default_nettype none
module rsd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [12:0]    cfg_wdata,
  input  wire logic           in_push,
  output logic                in_full,
  input  wire logic           in_opcode,
  input  wire logic [7:0]     in_data_byte,
  input  wire logic [11:0]    in_pixel_index,
  output logic                job_valid,
  output rsd_pkg::job_t       job,
  input  wire logic           job_full
);
  logic [12:0] width_r;
  rsd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] hb_r [4];
  logic [7:0] hb_nxt [4];
  logic [1:0] slot_r, slot_nxt;
  logic [1:0] chan_r, chan_nxt;
  logic [13:0] col_r, col_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [4:0] shift_r, shift_nxt;
  logic [13:0] w;
  logic acc;
  logic [7:0] b;

  assign in_full = job_full;
  assign acc = in_push && !job_full;
  assign b = in_data_byte;

  // Clamp width to 1..MaxWidth
  always_comb begin
    if (width_r == 13'd0) w = 14'd1;
    else if ({1'b0, width_r} > 14'(rsd_pkg::MaxWidth)) w = 14'(rsd_pkg::MaxWidth);
    else w = {1'b0, width_r};
  end

  // Decode one request
  always_comb begin
    logic [31:0] px;
    logic [13:0] room;
    logic [31:0] run;
    logic st, dn, flat;
    phase_nxt = phase_r;
    hb_nxt = hb_r;
    slot_nxt = slot_r;
    chan_nxt = chan_r;
    col_nxt = col_r;
    pend_nxt = pend_r;
    prev_nxt = prev_r;
    shift_nxt = shift_r;
    job = '0;
    job_valid = 1'b0;
    st = 1'b0;
    dn = 1'b0;
    flat = 1'b0;
    px = '0;
    room = w - col_r;
    run = '0;
    if (acc) begin
      job_valid = 1'b1;
      if (in_opcode == rsd_pkg::OP_READ) begin
        job.is_read = 1'b1;
        job.start = in_pixel_index;
      end else if (phase_r == rsd_pkg::PH_RLE) begin
        job.lane_mask = 4'b0001 << chan_r;
        job.pixel = {4{b}};
        job.start = col_r[11:0];
        if (pend_r == 8'd0) begin
          if (b > 8'd128) begin
            if (col_r + 14'(b - 8'd128) > w) st = 1'b1;
            else pend_nxt = b;
          end else if (b > 8'd0) begin
            if (col_r + 14'(b) > w) st = 1'b1;
            else pend_nxt = b;
          end
        end else if (pend_r > 8'd128) begin
          job.count = 13'(pend_r - 8'd128);
          col_nxt = col_r + 14'(pend_r - 8'd128);
          pend_nxt = 8'd0;
        end else begin
          job.count = 13'd1;
          col_nxt = col_r + 14'd1;
          pend_nxt = pend_r - 8'd1;
        end
        if (!st && col_nxt >= w) begin
          if (chan_r == 2'd3) dn = 1'b1;
          else begin
            chan_nxt = chan_r + 2'd1;
            col_nxt = '0;
            pend_nxt = '0;
          end
        end
      end else begin
        hb_nxt[slot_r] = b;
        slot_nxt = slot_r + 2'd1;
        if (slot_r == 2'd3) begin
          if (phase_r == rsd_pkg::PH_HEADER) begin
            col_nxt = '0;
            shift_nxt = '0;
            if (hb_r[0] == 8'd2 && hb_r[1] == 8'd2 && {hb_r[2], b} == 16'(w)
                && w >= 14'd8) begin
              phase_nxt = rsd_pkg::PH_RLE;
              chan_nxt = '0;
              pend_nxt = '0;
            end else begin
              phase_nxt = rsd_pkg::PH_FLAT;
              flat = 1'b1;
            end
          end else begin
            flat = 1'b1;
          end
        end
        // Flat pixel or old-style repeat
        if (flat) begin
          px = {b, hb_r[2], hb_r[1], hb_r[0]};
          room = w - col_nxt;
          job.lane_mask = 4'b1111;
          job.start = col_nxt[11:0];
          if (hb_r[0] == 8'd1 && hb_r[1] == 8'd1 && hb_r[2] == 8'd1 && col_nxt != 14'd0) begin
            run = 32'(b) << shift_r;
            if (run > 32'(room)) run = 32'(room);
            job.count = 13'(run);
            job.pixel = prev_r;
            col_nxt = col_nxt + 14'(run);
            shift_nxt = (shift_r >= 5'd16) ? 5'd24 : shift_r + 5'd8;
          end else begin
            job.count = 13'd1;
            job.pixel = px;
            prev_nxt = px;
            shift_nxt = '0;
            col_nxt = col_nxt + 14'd1;
          end
          if (col_nxt >= w) dn = 1'b1;
        end
      end
      // Restart line on overflow or completion
      if (st || dn) begin
        phase_nxt = rsd_pkg::PH_HEADER;
        slot_nxt = '0;
        chan_nxt = '0;
        col_nxt = '0;
        pend_nxt = '0;
        shift_nxt = '0;
      end
      job.status = st;
      job.line_done = dn;
    end
  end

  // Hold decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 13'd8;
      phase_r <= rsd_pkg::PH_HEADER;
      for (int i = 0; i < 4; i++) hb_r[i] <= '0;
      slot_r <= '0;
      chan_r <= '0;
      col_r <= '0;
      pend_r <= '0;
      prev_r <= '0;
      shift_r <= '0;
    end else if (cfg_we) begin
      width_r <= cfg_wdata;
      phase_r <= rsd_pkg::PH_HEADER;
      slot_r <= '0;
      chan_r <= '0;
      col_r <= '0;
      pend_r <= '0;
      shift_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      hb_r <= hb_nxt;
      slot_r <= slot_nxt;
      chan_r <= chan_nxt;
      col_r <= col_nxt;
      pend_r <= pend_nxt;
      prev_r <= prev_nxt;
      shift_r <= shift_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/rsd_queue.sv -----
// Two-entry job queue between front and back.
// Depends on rsd_pkg.
`default_nettype none
module rsd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire rsd_pkg::job_t wr_job,
  output logic               full,
  output logic               rd_valid,
  output rsd_pkg::job_t      rd_job,
  input  wire logic          rd_en
);
  rsd_pkg::job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job = mem_r[rp_r];

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_job;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/rsd_back.sv -----
// Back part: writes spans into the line buffer and serves pixel reads.
// Depends on rsd_pkg; holds the line buffer memory.
`default_nettype none
module rsd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_valid,
  input  wire rsd_pkg::job_t job,
  output logic               job_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output logic               out_status,
  output logic               out_line_done,
  output logic [31:0]        out_red_bits,
  output logic [31:0]        out_green_bits,
  output logic [31:0]        out_blue_bits
);
  logic [7:0] mem0 [rsd_pkg::MaxWidth];
  logic [7:0] mem1 [rsd_pkg::MaxWidth];
  logic [7:0] mem2 [rsd_pkg::MaxWidth];
  logic [7:0] mem3 [rsd_pkg::MaxWidth];
  logic [31:0] rd_r;
  rsd_pkg::back_state_t st_r, st_nxt;
  logic [12:0] left_r, left_nxt;
  logic [11:0] addr_r, addr_nxt;
  logic ov_r, ov_nxt;
  logic res_st_r, res_dn_r;
  logic [31:0] r_r, g_r, b_r;
  logic res_nxt, wr_en;
  logic [31:0] r_nxt, g_nxt, b_nxt;
  logic st_nx, dn_nx;

  assign out_empty = !ov_r;
  assign out_status = res_st_r;
  assign out_line_done = res_dn_r;
  assign out_red_bits = r_r;
  assign out_green_bits = g_r;
  assign out_blue_bits = b_r;

  // Sequence jobs: fill one entry per cycle, reads go through the registered memory port
  always_comb begin
    st_nxt = st_r;
    left_nxt = left_r;
    addr_nxt = addr_r;
    job_pop = 1'b0;
    res_nxt = 1'b0;
    wr_en = 1'b0;
    r_nxt = '0;
    g_nxt = '0;
    b_nxt = '0;
    st_nx = 1'b0;
    dn_nx = 1'b0;
    case (st_r)
      rsd_pkg::BK_IDLE: begin
        if (job_valid && (!ov_r || out_pop)) begin
          job_pop = 1'b1;
          addr_nxt = job.start;
          if (job.is_read) begin
            st_nxt = rsd_pkg::BK_READ;
          end else begin
            left_nxt = job.count;
            st_nxt = rsd_pkg::BK_FILL;
            res_nxt = 1'b1;
            st_nx = job.status;
            dn_nx = job.line_done;
          end
        end
      end
      rsd_pkg::BK_FILL: begin
        if (left_r == 13'd0) st_nxt = rsd_pkg::BK_IDLE;
        else begin
          wr_en = 1'b1;
          addr_nxt = addr_r + 12'd1;
          left_nxt = left_r - 13'd1;
          if (left_r == 13'd1) st_nxt = rsd_pkg::BK_IDLE;
        end
      end
      rsd_pkg::BK_READ: st_nxt = rsd_pkg::BK_READ2;
      rsd_pkg::BK_READ2: begin
        if (!ov_r || out_pop) begin
          res_nxt = 1'b1;
          r_nxt = rsd_pkg::chan_bits(rd_r[7:0], rd_r[31:24]);
          g_nxt = rsd_pkg::chan_bits(rd_r[15:8], rd_r[31:24]);
          b_nxt = rsd_pkg::chan_bits(rd_r[23:16], rd_r[31:24]);
          st_nxt = rsd_pkg::BK_IDLE;
        end
      end
      default: st_nxt = rsd_pkg::BK_IDLE;
    endcase
    ov_nxt = res_nxt ? 1'b1 : (out_pop ? 1'b0 : ov_r);
  end

  // Hold span value and lane mask for the fill
  logic [31:0] px_r;
  logic [3:0] mask_r;
  always_ff @(posedge clk) begin
    if (job_pop) begin
      px_r <= job.pixel;
      mask_r <= job.lane_mask;
    end
  end

  // Line buffer, one byte lane per channel
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (mask_r[0]) mem0[addr_r] <= px_r[7:0];
      if (mask_r[1]) mem1[addr_r] <= px_r[15:8];
      if (mask_r[2]) mem2[addr_r] <= px_r[23:16];
      if (mask_r[3]) mem3[addr_r] <= px_r[31:24];
    end
    rd_r <= {mem3[addr_r], mem2[addr_r], mem1[addr_r], mem0[addr_r]};
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rsd_pkg::BK_IDLE;
      ov_r <= 1'b0;
      left_r <= '0;
      addr_r <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      left_r <= left_nxt;
      addr_r <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_nxt) begin
      res_st_r <= st_nx;
      res_dn_r <= dn_nx;
      r_r <= r_nxt;
      g_r <= g_nxt;
      b_r <= b_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/rsd_checker.sv -----
// Port-level checker for the RGBE scanline decoder, bound to the top level.
// Depends on rgbe_scanline_decoder ports only.
`default_nettype none
module rsd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        out_status,
  input wire logic        out_line_done,
  input wire logic [31:0] out_red_bits
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    empty == 1'b0 && !pop |=> empty == 1'b0) else $error("result dropped");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_status |-> !out_line_done) else $error("status with done");
  a_feed: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_status || out_line_done) |-> out_red_bits == 32'd0)
    else $error("feed result carries pixel");
endmodule

bind rgbe_scanline_decoder rsd_checker u_chk (
  .clk, .rst_n, .empty, .pop, .out_status, .out_line_done, .out_red_bits
);
`default_nettype wire
